[hdl/sot_pkg.sv]
package sot_pkg;

   // Field and datapath widths
   localparam int FIELD_W    = 32;
   localparam int DIFF_W     = FIELD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int SUM_W      = SQ_W + 1;
   localparam int LEN_W      = 62;
   localparam int FRAC_SHIFT = 30;
   localparam int NUM_W      = LEN_W + FRAC_SHIFT;
   localparam int ACC_W      = 96;
   localparam int ROOT_W     = 16;
   localparam int Q_W        = ROOT_W + 1;
   localparam int NORM_W     = 16;
   localparam int KIND_W     = 3;
   localparam int N_CHECK    = 4;
   localparam int IDX_W      = 2;

   // Queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = PTR_W + 1;

   // Unit length in Q2.14
   localparam logic [NORM_W-1:0] ONE_Q14 = NORM_W'(16384);

   // Pair kinds on the request channel
   localparam logic [KIND_W-1:0] KIND_BB = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BC = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CB = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CC = 3'd3;

   // Internal operation codes
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_BB   = 2'd1;
   localparam logic [1:0] OP_BC   = 2'd2;
   localparam logic [1:0] OP_CC   = 2'd3;

   typedef logic [FIELD_W-1:0] coord_type;

   // Classified pair: for box/circle, a is the box and b the circle
   typedef struct packed {
      logic [1:0]          op;
      logic                flip;
      coord_type [3:0]     a;
      coord_type [3:0]     b;
   } item_type;

   // Result info riding along the root pipeline
   typedef struct packed {
      logic              hit;
      logic              wrote;
      logic              axis;
      logic [IDX_W-1:0]  idx;
      logic              flip;
      logic              negx;
      logic              negy;
      logic              lzero;
   } side_type;

   // Axis normal of extreme point idx: left, bottom, right, top
   function automatic logic [NORM_W-1:0] axis_x(input logic [IDX_W-1:0] idx);
      logic [NORM_W-1:0] v;
      unique case (idx)
         2'd0:    v = -ONE_Q14;
         2'd2:    v = ONE_Q14;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [NORM_W-1:0] axis_y(input logic [IDX_W-1:0] idx);
      logic [NORM_W-1:0] v;
      unique case (idx)
         2'd1:    v = -ONE_Q14;
         2'd3:    v = ONE_Q14;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hdl/sot_front.sv]
module sot_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sot_pkg::KIND_W-1:0]    req_kind,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_coord_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_coord_y,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_extent_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_extent_y,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_coord_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_coord_y,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_extent_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_extent_y,
   input  logic                          full,
   output logic                          push,
   output sot_pkg::item_type             item
);

   localparam int EFF_W = (COORD_WIDTH < sot_pkg::FIELD_W) ? COORD_WIDTH : sot_pkg::FIELD_W;
   localparam int SH    = sot_pkg::FIELD_W - EFF_W;

   // Sign-extend from the coordinate width
   function automatic sot_pkg::coord_type sx(input logic [sot_pkg::FIELD_W-1:0] v);
      logic [sot_pkg::FIELD_W-1:0] t;
      t = v << SH;
      return $unsigned($signed(t) >>> SH);
   endfunction

   sot_pkg::coord_type [3:0] first_w;
   sot_pkg::coord_type [3:0] second_w;

   assign first_w[0]  = sx(req_first_coord_x);
   assign first_w[1]  = sx(req_first_coord_y);
   assign first_w[2]  = sx(req_first_extent_x);
   assign first_w[3]  = sx(req_first_extent_y);
   assign second_w[0] = sx(req_second_coord_x);
   assign second_w[1] = sx(req_second_coord_y);
   assign second_w[2] = sx(req_second_extent_x);
   assign second_w[3] = sx(req_second_extent_y);

   assign req_ready = !full;
   assign push      = req_valid && !full;

   // Classify the pair; box always goes in a for mixed pairs
   always_comb begin
      item.op   = sot_pkg::OP_NONE;
      item.flip = 1'b0;
      item.a    = first_w;
      item.b    = second_w;
      unique case (req_kind)
         sot_pkg::KIND_BB: item.op = sot_pkg::OP_BB;
         sot_pkg::KIND_BC: item.op = sot_pkg::OP_BC;
         sot_pkg::KIND_CB: begin
            item.op   = sot_pkg::OP_BC;
            item.flip = 1'b1;
            item.a    = second_w;
            item.b    = first_w;
         end
         sot_pkg::KIND_CC: item.op = sot_pkg::OP_CC;
         default:          item.op = sot_pkg::OP_NONE;
      endcase
   end

endmodule

[hdl/sot_fifo.sv]
module sot_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sot_pkg::item_type push_item,
   input  logic              pop,
   output sot_pkg::item_type head,
   output logic              head_valid,
   output logic              full
);

   sot_pkg::item_type               mem_ff [sot_pkg::FIFO_DEPTH];
   logic [sot_pkg::PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [sot_pkg::CNT_W-1:0]       count_ff;
   logic                            do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == sot_pkg::CNT_W'(sot_pkg::FIFO_DEPTH));
   assign head       = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[hdl/sot_isqrt.sv]
// Pipelined search for the largest m with m*m*len <= num, one bit per stage.
module sot_isqrt (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [sot_pkg::NUM_W-1:0]    num,
   input  logic [sot_pkg::LEN_W-1:0]    len_sq,
   output logic [sot_pkg::ROOT_W-1:0]   root
);

   localparam int RW = sot_pkg::ROOT_W;
   localparam int AW = sot_pkg::ACC_W;

   // r: remaining num - m*m*len, t: m*len
   logic [AW-1:0]              r_ff [RW];
   logic [AW-1:0]              t_ff [RW];
   logic [sot_pkg::LEN_W-1:0]  l_ff [RW];
   logic [RW-1:0]              m_ff [RW];
   logic [AW-1:0]              r_in [RW];
   logic [AW-1:0]              t_in [RW];
   logic [sot_pkg::LEN_W-1:0]  l_in [RW];
   logic [RW-1:0]              m_in [RW];
   logic [AW-1:0]              rp, tp, lp, d;
   logic [RW-1:0]              mp;
   logic                       take;

   // Each stage tries bit (RW-1-j): adding it costs 2^(k+1)*m*len + 2^(2k)*len
   always_comb begin
      for (int j = 0; j < RW; j++) begin
         if (j == 0) begin
            rp = AW'(num);
            tp = '0;
            lp = AW'(len_sq);
            mp = '0;
         end else begin
            rp = r_ff[j-1];
            tp = t_ff[j-1];
            lp = AW'(l_ff[j-1]);
            mp = m_ff[j-1];
         end
         d       = (tp << (RW - j)) + (lp << (2 * (RW - 1 - j)));
         take    = (d <= rp);
         r_in[j] = take ? rp - d : rp;
         t_in[j] = take ? tp + (lp << (RW - 1 - j)) : tp;
         l_in[j] = lp[sot_pkg::LEN_W-1:0];
         m_in[j] = take ? (mp | (RW'(1) << (RW - 1 - j))) : mp;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < RW; j++) begin
            r_ff[j] <= r_in[j];
            t_ff[j] <= t_in[j];
            l_ff[j] <= l_in[j];
            m_ff[j] <= m_in[j];
         end
      end
   end

   assign root = m_ff[RW-1];

endmodule

[hdl/sot_back.sv]
module sot_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  sot_pkg::item_type                 head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic                              rsp_normal_written,
   output logic signed [sot_pkg::NORM_W-1:0] rsp_normal_x,
   output logic signed [sot_pkg::NORM_W-1:0] rsp_normal_y
);

   localparam int DW = sot_pkg::DIFF_W;
   localparam int RW = sot_pkg::ROOT_W;

   typedef struct packed {
      logic [1:0]              op;
      logic                    flip;
      logic                    bbhit;
      logic                    ccpos;
      logic [3:0]              ext;
      logic [3:0][DW-1:0]      mdx;
      logic [3:0][DW-1:0]      mdy;
      logic [3:0]              sdx;
      logic [3:0]              sdy;
      logic [DW-1:0]           mrad;
   } s1_type;

   typedef struct packed {
      logic [1:0]                      op;
      logic                            flip;
      logic                            bbhit;
      logic                            ccpos;
      logic [3:0]                      ext;
      logic [3:0]                      sdx;
      logic [3:0]                      sdy;
      logic [3:0][sot_pkg::SQ_W-1:0]   sqx;
      logic [3:0][sot_pkg::SQ_W-1:0]   sqy;
      logic [sot_pkg::SQ_W-1:0]        r2;
   } s2_type;

   typedef struct packed {
      logic [1:0]                      op;
      logic                            flip;
      logic                            bbhit;
      logic                            ccpos;
      logic [3:0]                      ext;
      logic [3:0]                      sdx;
      logic [3:0]                      sdy;
      logic [3:0][sot_pkg::SQ_W-1:0]   sqx;
      logic [3:0][sot_pkg::SUM_W-1:0]  sum;
      logic [3:0]                      in_circ;
   } s3_type;

   function automatic logic signed [DW-1:0] ext_d(input sot_pkg::coord_type v);
      return $signed({v[sot_pkg::FIELD_W-1], v});
   endfunction

   function automatic logic [DW-1:0] abs_d(input logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   logic                          adv;
   logic                          v1_ff, v2_ff, v3_ff, v4_ff;
   logic                          vr_ff [RW];
   logic                          rsp_valid_ff;
   s1_type                        s1_ff, s1_in;
   s2_type                        s2_ff, s2_in;
   s3_type                        s3_ff, s3_in;
   sot_pkg::side_type             side4_ff, side4_in;
   sot_pkg::side_type             side_ff [RW];
   logic [sot_pkg::NUM_W-1:0]     numx_ff, numx_in, numy_ff, numy_in;
   logic [sot_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [RW-1:0]                 root_x, root_y;
   logic                          hit_ff, wrote_ff;
   logic [sot_pkg::NORM_W-1:0]    nx_ff, ny_ff, nx_in, ny_in;

   logic signed [DW-1:0]          mnx, mny, mxx, mxy, cx, cy, rad, px, py, kx, ky, dx, dy;
   logic [sot_pkg::LEN_W-1:0]     selx, sely;
   logic                          found;
   logic [sot_pkg::Q_W-1:0]       qx, qy;
   sot_pkg::side_type             fin;

   // Whole pipeline moves when the output register is free or drained
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && head_valid;

   // Stage 1: differences, extreme-point tests, box-box compare
   always_comb begin
      mnx = ext_d(head.a[0]);
      mny = ext_d(head.a[1]);
      mxx = ext_d(head.a[2]);
      mxy = ext_d(head.a[3]);
      cx  = ext_d(head.b[0]);
      cy  = ext_d(head.b[1]);
      s1_in       = '0;
      s1_in.op    = head.op;
      s1_in.flip  = head.flip;
      s1_in.bbhit = (mnx < ext_d(head.b[2])) && (mxx > cx) &&
                    (mny < ext_d(head.b[3])) && (mxy > cy);
      rad = (head.op == sot_pkg::OP_CC) ? ext_d(head.a[2]) + ext_d(head.b[2])
                                        : ext_d(head.b[2]);
      for (int i = 0; i < sot_pkg::N_CHECK; i++) begin
         px = cx;
         py = cy;
         case (i)
            0:       px = cx - rad;
            1:       py = cy - rad;
            2:       px = cx + rad;
            default: py = cy + rad;
         endcase
         s1_in.ext[i] = (px > mnx) && (px < mxx) && (py > mny) && (py < mxy);
         kx = ((i & 2) != 0) ? mxx : mnx;
         ky = ((i & 1) != 0) ? mxy : mny;
         dx = kx - cx;
         dy = ky - cy;
         // circle pair reuses the first slot for the center difference
         if (i == 0 && head.op == sot_pkg::OP_CC) begin
            dx = mnx - cx;
            dy = mny - cy;
         end
         s1_in.mdx[i] = abs_d(dx);
         s1_in.mdy[i] = abs_d(dy);
         s1_in.sdx[i] = dx[DW-1];
         s1_in.sdy[i] = dy[DW-1];
      end
      s1_in.ccpos = (rad > 0);
      s1_in.mrad  = abs_d(rad);
   end

   // Stage 2: squares
   always_comb begin
      s2_in.op    = s1_ff.op;
      s2_in.flip  = s1_ff.flip;
      s2_in.bbhit = s1_ff.bbhit;
      s2_in.ccpos = s1_ff.ccpos;
      s2_in.ext   = s1_ff.ext;
      s2_in.sdx   = s1_ff.sdx;
      s2_in.sdy   = s1_ff.sdy;
      for (int i = 0; i < sot_pkg::N_CHECK; i++) begin
         s2_in.sqx[i] = s1_ff.mdx[i] * s1_ff.mdx[i];
         s2_in.sqy[i] = s1_ff.mdy[i] * s1_ff.mdy[i];
      end
      s2_in.r2 = s1_ff.mrad * s1_ff.mrad;
   end

   // Stage 3: squared distances against the squared radius
   always_comb begin
      s3_in.op    = s2_ff.op;
      s3_in.flip  = s2_ff.flip;
      s3_in.bbhit = s2_ff.bbhit;
      s3_in.ccpos = s2_ff.ccpos;
      s3_in.ext   = s2_ff.ext;
      s3_in.sdx   = s2_ff.sdx;
      s3_in.sdy   = s2_ff.sdy;
      s3_in.sqx   = s2_ff.sqx;
      for (int i = 0; i < sot_pkg::N_CHECK; i++) begin
         s3_in.sum[i]     = sot_pkg::SUM_W'(s2_ff.sqx[i]) + sot_pkg::SUM_W'(s2_ff.sqy[i]);
         s3_in.in_circ[i] = s3_in.sum[i] < sot_pkg::SUM_W'(s2_ff.r2);
      end
   end

   // Stage 4: first test that fires wins; set up the normal division
   always_comb begin
      found          = 1'b0;
      side4_in       = '0;
      side4_in.flip  = s3_ff.flip;
      for (int i = 0; i < sot_pkg::N_CHECK; i++) begin
         if (!found) begin
            if (s3_ff.ext[i]) begin
               found         = 1'b1;
               side4_in.axis = 1'b1;
               side4_in.idx  = sot_pkg::IDX_W'(i);
            end else if (s3_ff.in_circ[i]) begin
               found         = 1'b1;
               side4_in.axis = 1'b0;
               side4_in.idx  = sot_pkg::IDX_W'(i);
            end
         end
      end
      unique case (s3_ff.op)
         sot_pkg::OP_BB: side4_in.hit = s3_ff.bbhit;
         sot_pkg::OP_BC: side4_in.hit = found;
         sot_pkg::OP_CC: side4_in.hit = s3_ff.ccpos && s3_ff.in_circ[0];
         default:        side4_in.hit = 1'b0;
      endcase
      side4_in.wrote = (s3_ff.op == sot_pkg::OP_BC) && found;
      side4_in.negx  = s3_ff.sdx[side4_in.idx] ^ s3_ff.flip;
      side4_in.negy  = s3_ff.sdy[side4_in.idx] ^ s3_ff.flip;
      selx     = s3_ff.sqx[side4_in.idx][sot_pkg::LEN_W-1:0];
      sely     = s3_ff.sum[side4_in.idx][sot_pkg::LEN_W-1:0]
                 - selx;
      len_in   = s3_ff.sum[side4_in.idx][sot_pkg::LEN_W-1:0];
      side4_in.lzero = (len_in == '0);
      numx_in  = {selx, {sot_pkg::FRAC_SHIFT{1'b0}}};
      numy_in  = {sely, {sot_pkg::FRAC_SHIFT{1'b0}}};
   end

   sot_isqrt u_root_x (
      .clock  (clock),
      .enable (adv),
      .num    (numx_ff),
      .len_sq (len_ff),
      .root   (root_x)
   );

   sot_isqrt u_root_y (
      .clock  (clock),
      .enable (adv),
      .num    (numy_ff),
      .len_sq (len_ff),
      .root   (root_y)
   );

   // Final: round roots into Q2.14, clamp at one and apply signs
   always_comb begin
      fin = side_ff[RW-1];
      qx  = (sot_pkg::Q_W'(root_x) + sot_pkg::Q_W'(1)) >> 1;
      qy  = (sot_pkg::Q_W'(root_y) + sot_pkg::Q_W'(1)) >> 1;
      if (fin.lzero) begin
         qx = '0;
         qy = '0;
      end
      if (qx > sot_pkg::Q_W'(sot_pkg::ONE_Q14)) begin
         qx = sot_pkg::Q_W'(sot_pkg::ONE_Q14);
      end
      if (qy > sot_pkg::Q_W'(sot_pkg::ONE_Q14)) begin
         qy = sot_pkg::Q_W'(sot_pkg::ONE_Q14);
      end
      if (!fin.wrote) begin
         nx_in = '0;
         ny_in = '0;
      end else if (fin.axis) begin
         nx_in = fin.flip ? -sot_pkg::axis_x(fin.idx) : sot_pkg::axis_x(fin.idx);
         ny_in = fin.flip ? -sot_pkg::axis_y(fin.idx) : sot_pkg::axis_y(fin.idx);
      end else begin
         nx_in = fin.negx ? -sot_pkg::NORM_W'(qx) : sot_pkg::NORM_W'(qx);
         ny_in = fin.negy ? -sot_pkg::NORM_W'(qy) : sot_pkg::NORM_W'(qy);
      end
   end

   // Valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < RW; j++) begin
            vr_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= head_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         vr_ff[0] <= v4_ff;
         for (int j = 1; j < RW; j++) begin
            vr_ff[j] <= vr_ff[j-1];
         end
         rsp_valid_ff <= vr_ff[RW-1];
      end
   end

   // Payload line
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         side4_ff   <= side4_in;
         numx_ff    <= numx_in;
         numy_ff    <= numy_in;
         len_ff     <= len_in;
         side_ff[0] <= side4_ff;
         for (int j = 1; j < RW; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
         hit_ff   <= fin.hit;
         wrote_ff <= fin.wrote;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_normal_written = wrote_ff;
   assign rsp_normal_x       = $signed(nx_ff);
   assign rsp_normal_y       = $signed(ny_ff);

endmodule

[hdl/shape_overlap_test_2d.sv]
// Overlap test for a pair of placed 2D shapes (boxes by min/max corners,
// circles by center and radius), with a unit contact normal for box/circle.
// Request channel (req_*): one beat per pair, valid/ready handshake; the
// kind field selects box-box, box-circle, circle-box or circle-circle.
// Response channel (rsp_*): one beat per request, in request order, with
// hit, normal_written and the Q2.14 normal (zero when not written).
// Throughput: one pair per cycle while rsp_ready does not hold the pipe.
// The compute pipe has the 4 geometry stages, the 16-stage bit-serial
// normalization (one root bit per stage) and the output register.
// A 4-deep queue sits between the input classifier and the compute pipe,
// so requests keep being taken while a response waits on rsp_ready.
// When rsp_ready is low under a valid response the compute pipe holds;
// req_ready drops only once the queue is full. Synchronous reset empties
// the queue and the pipe; no response is valid in the cycle after reset.
module shape_overlap_test_2d #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sot_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_coord_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_coord_y,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_extent_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_first_extent_y,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_coord_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_coord_y,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_extent_x,
   input  logic signed [sot_pkg::FIELD_W-1:0] req_second_extent_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic                               rsp_normal_written,
   output logic signed [sot_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [sot_pkg::NORM_W-1:0]  rsp_normal_y
);

   logic              full, push, pop, head_valid;
   sot_pkg::item_type item, head;

   sot_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_first_coord_x   (req_first_coord_x),
      .req_first_coord_y   (req_first_coord_y),
      .req_first_extent_x  (req_first_extent_x),
      .req_first_extent_y  (req_first_extent_y),
      .req_second_coord_x  (req_second_coord_x),
      .req_second_coord_y  (req_second_coord_y),
      .req_second_extent_x (req_second_extent_x),
      .req_second_extent_y (req_second_extent_y),
      .full                (full),
      .push                (push),
      .item                (item)
   );

   sot_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (item),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   sot_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_normal_written (rsp_normal_written),
      .rsp_normal_x       (rsp_normal_x),
      .rsp_normal_y       (rsp_normal_y)
   );

endmodule

[hdl/sot_checker.sv]
module sot_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_hit,
   input logic                               rsp_normal_written,
   input logic signed [sot_pkg::NORM_W-1:0]  rsp_normal_x,
   input logic signed [sot_pkg::NORM_W-1:0]  rsp_normal_y
);

   // A normal only comes with a hit
   a_normal_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_written |-> rsp_hit)
      else $error("normal written without hit");

   // No normal means zero components
   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_normal_written |-> rsp_normal_x == 0 && rsp_normal_y == 0)
      else $error("normal fields not zero");

   // Components stay within unit range
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x >= -16384 && rsp_normal_x <= 16384 &&
                    rsp_normal_y >= -16384 && rsp_normal_y <= 16384)
      else $error("normal out of range");

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) &&
                                  $stable(rsp_normal_x) && $stable(rsp_normal_y))
      else $error("response changed while stalled");

   // Pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind shape_overlap_test_2d sot_checker u_sot_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_hit            (rsp_hit),
   .rsp_normal_written (rsp_normal_written),
   .rsp_normal_x       (rsp_normal_x),
   .rsp_normal_y       (rsp_normal_y)
);

[test/shape_overlap_checker.sv]
module shape_overlap_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_first_coord_x,
   input  logic [31:0] req_first_coord_y,
   input  logic [31:0] req_first_extent_x,
   input  logic [31:0] req_first_extent_y,
   input  logic [31:0] req_second_coord_x,
   input  logic [31:0] req_second_coord_y,
   input  logic [31:0] req_second_extent_x,
   input  logic [31:0] req_second_extent_y,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_hit,
   input  logic        rsp_normal_written,
   input  logic [15:0] rsp_normal_x,
   input  logic [15:0] rsp_normal_y,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic        hit;
      logic        wrote;
      logic [15:0] nx;
      logic [15:0] ny;
   } contact_type;

   contact_type expected_contacts[$];

   // Rounded Q2.14 magnitude of a / sqrt(len2), exact by bisection
   function automatic longint unit_component(longint unsigned a, longint unsigned len2);
      logic [127:0] lhs;
      logic [127:0] rhs;
      longint lo;
      longint hi;
      longint q;
      longint unsigned t;
      lo = 0;
      hi = 16384;
      if (len2 == 0) return 0;
      lhs = {64'd0, a * a} << 30;
      while (lo < hi) begin
         q = (lo + hi + 1) / 2;
         t = 2 * q - 1;
         rhs = 128'(t * t) * 128'(len2);
         if (!(lhs < rhs)) lo = q;
         else hi = q - 1;
      end
      return lo;
   endfunction

   function automatic logic [127:0] square_sum(longint dx, longint dy);
      logic [127:0] ax;
      logic [127:0] ay;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      return ax * ax + ay * ay;
   endfunction

   function automatic contact_type box_vs_circle(longint mnx, longint mny, longint mxx,
         longint mxy, longint cx, longint cy, longint r, bit flip);
      contact_type c;
      longint ax[4];
      longint ay[4];
      longint px, py, kx, ky, dx, dy, ux, uy;
      logic [127:0] r2;
      longint unsigned l2;
      ax = '{-1, 0, 1, 0};
      ay = '{0, -1, 0, 1};
      c = '0;
      r2 = 128'(r < 0 ? -r : r) * 128'(r < 0 ? -r : r);
      for (int i = 0; i < 4; i++) begin
         px = cx + ax[i] * r;
         py = cy + ay[i] * r;
         kx = (i & 2) ? mxx : mnx;
         ky = (i & 1) ? mxy : mny;
         // extreme point of the circle strictly inside the box
         if (px > mnx && px < mxx && py > mny && py < mxy) begin
            c.hit = 1;
            c.wrote = 1;
            c.nx = 16'((flip ? -ax[i] : ax[i]) * 16384);
            c.ny = 16'((flip ? -ay[i] : ay[i]) * 16384);
            return c;
         end
         // box corner strictly inside the circle
         if (square_sum(kx - cx, ky - cy) < r2) begin
            dx = flip ? cx - kx : kx - cx;
            dy = flip ? cy - ky : ky - cy;
            l2 = 64'(square_sum(dx, dy));
            ux = unit_component(dx < 0 ? -dx : dx, l2);
            uy = unit_component(dy < 0 ? -dy : dy, l2);
            c.hit = 1;
            c.wrote = 1;
            c.nx = 16'(dx < 0 ? -ux : ux);
            c.ny = 16'(dy < 0 ? -uy : uy);
            return c;
         end
      end
      return c;
   endfunction

   function automatic contact_type predict_contact(logic [2:0] kind, longint a[4], longint b[4]);
      contact_type c;
      longint s;
      c = '0;
      case (kind)
         sot_pkg::KIND_BB: c.hit = a[0] < b[2] && a[2] > b[0] && a[1] < b[3] && a[3] > b[1];
         sot_pkg::KIND_BC: c = box_vs_circle(a[0], a[1], a[2], a[3], b[0], b[1], b[2], 0);
         sot_pkg::KIND_CB: c = box_vs_circle(b[0], b[1], b[2], b[3], a[0], a[1], a[2], 1);
         sot_pkg::KIND_CC: begin
            s = a[2] + b[2];
            if (s > 0) c.hit = square_sum(a[0] - b[0], a[1] - b[1]) < 128'(s) * 128'(s);
         end
         default: c = '0;
      endcase
      return c;
   endfunction

   assign pending = expected_contacts.size();

   always @(posedge clock) begin
      longint a[4];
      longint b[4];
      contact_type want;
      if (reset) begin
         expected_contacts.delete();
         fail_count <= 0;
      end else begin
         // predict on each request beat
         if (req_valid && req_ready) begin
            a = '{longint'(signed'(req_first_coord_x)), longint'(signed'(req_first_coord_y)),
                  longint'(signed'(req_first_extent_x)), longint'(signed'(req_first_extent_y))};
            b = '{longint'(signed'(req_second_coord_x)), longint'(signed'(req_second_coord_y)),
                  longint'(signed'(req_second_extent_x)), longint'(signed'(req_second_extent_y))};
            expected_contacts.push_back(predict_contact(req_kind, a, b));
         end
         // compare each response beat
         if (rsp_valid && rsp_ready) begin
            if (expected_contacts.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_contacts.pop_front();
               if (want.hit !== rsp_hit || want.wrote !== rsp_normal_written ||
                   want.nx !== rsp_normal_x || want.ny !== rsp_normal_y) begin
                  if (want.hit !== rsp_hit)
                     $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  if (want.wrote !== rsp_normal_written)
                     $error("normal_written: expected %0d, got %0d", want.wrote,
                            rsp_normal_written);
                  if (want.nx !== rsp_normal_x)
                     $error("normal_x: expected %0d, got %0d", signed'(want.nx),
                            signed'(rsp_normal_x));
                  if (want.ny !== rsp_normal_y)
                     $error("normal_y: expected %0d, got %0d", signed'(want.ny),
                            signed'(rsp_normal_y));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[test/shape_overlap_test_2d_tb.sv]
module shape_overlap_test_2d_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_kind;
   logic signed [31:0] req_first_coord_x, req_first_coord_y;
   logic signed [31:0] req_first_extent_x, req_first_extent_y;
   logic signed [31:0] req_second_coord_x, req_second_coord_y;
   logic signed [31:0] req_second_extent_x, req_second_extent_y;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_hit;
   logic        rsp_normal_written;
   logic signed [15:0] rsp_normal_x, rsp_normal_y;
   int          fail_count;
   int          pending;
   bit          hold_rsp;
   int          idle_cycles;

   shape_overlap_test_2d dut (.*);

   shape_overlap_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Build one pair; coords a, b of 4 words each. Valid stays up into the
   // next beat when there is no gap.
   task automatic send_pair(logic [2:0] kind, logic [31:0] a0, logic [31:0] a1,
         logic [31:0] a2, logic [31:0] a3, logic [31:0] b0, logic [31:0] b1,
         logic [31:0] b2, logic [31:0] b3);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_first_coord_x <= a0;
      req_first_coord_y <= a1;
      req_first_extent_x <= a2;
      req_first_extent_y <= a3;
      req_second_coord_x <= b0;
      req_second_coord_y <= b1;
      req_second_extent_x <= b2;
      req_second_extent_y <= b3;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random coordinate: mostly small Q16.16 scenes, sometimes full range
   function automatic logic [31:0] rand_coord(int unsigned span);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return 32'($urandom_range(0, span)) - 32'(span / 2);
   endfunction

   task automatic send_random_pair();
      logic [2:0] kind;
      logic [31:0] v[8];
      int unsigned span;
      kind = $urandom_range(0, 9) == 0 ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      span = $urandom_range(0, 1) ? 32'h0008_0000 : 32'h0100_0000;
      foreach (v[i]) v[i] = rand_coord(span);
      // well-formed shapes: max above min, radius mostly positive
      if ($urandom_range(0, 7) != 0) begin
         v[2] = v[0] + $urandom_range(0, span);
         v[3] = v[1] + $urandom_range(0, span);
         v[6] = v[4] + $urandom_range(0, span);
         v[7] = v[5] + $urandom_range(0, span);
         if (kind == sot_pkg::KIND_CB || kind == sot_pkg::KIND_CC)
            v[2] = $urandom_range(0, span);
         if (kind == sot_pkg::KIND_BC || kind == sot_pkg::KIND_CC)
            v[6] = $urandom_range(0, span);
      end
      send_pair(kind, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
   endtask

   // Response side: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         idle_cycles <= 0;
      end else if (hold_rsp) begin
         rsp_ready <= 0;
      end else if (idle_cycles > 0) begin
         rsp_ready <= 0;
         idle_cycles <= idle_cycles - 1;
      end else if (rsp_valid && rsp_ready) begin
         idle_cycles <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   // Long receiver hold-off, counted in its own process
   initial begin
      hold_rsp = 0;
      wait (!reset);
      repeat (200) @(posedge clock);
      hold_rsp = 1;
      repeat (60) @(posedge clock);
      hold_rsp = 0;
   end

   // Watchdog on cycles with no beat
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet > 2000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] big, neg;
      big = 32'h7FFF_FFFF;
      neg = 32'h8000_0000;
      reset <= 1;
      req_valid <= 0;
      req_kind <= '0;
      req_first_coord_x <= 0;
      req_first_coord_y <= 0;
      req_first_extent_x <= 0;
      req_first_extent_y <= 0;
      req_second_coord_x <= 0;
      req_second_coord_y <= 0;
      req_second_extent_x <= 0;
      req_second_extent_y <= 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed pairs
      send_pair(sot_pkg::KIND_BB, 0, 0, 32'h10000, 32'h10000, 32'h8000, 32'h8000,
                32'h20000, 32'h20000);
      send_pair(sot_pkg::KIND_BB, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0,
                32'h20000, 32'h10000);
      send_pair(sot_pkg::KIND_BB, neg, neg, big, big, neg, neg, big, big);
      send_pair(sot_pkg::KIND_BB, big, big, neg, neg, 0, 0, 1, 1);
      // extreme points inside the box (left and bottom), one corner hit
      send_pair(sot_pkg::KIND_BC, 0, 0, 32'h40000, 32'h40000, 32'h30000, 32'h20000,
                32'h18000, 0);
      send_pair(sot_pkg::KIND_BC, 0, 0, 32'h40000, 32'h10000, 32'h20000, 32'h18000,
                32'h10000, 0);
      send_pair(sot_pkg::KIND_CB, 32'h20000, 32'h20000, 32'h30000, 0, 0, 0,
                32'h10000, 32'h40000);
      send_pair(sot_pkg::KIND_CB, 32'h20000, 32'h3000, 32'h8000, 0, 0, 0,
                32'h40000, 32'h10000);
      // circle near a box corner, no contact
      send_pair(sot_pkg::KIND_BC, 0, 0, 32'h10000, 32'h10000, 32'h1C000, 32'h1E000,
                32'h8000, 0);
      send_pair(sot_pkg::KIND_CB, 32'h1C000, 32'h1E000, 32'h8000, 0, 0, 0,
                32'h10000, 32'h10000);
      // corner on center
      send_pair(sot_pkg::KIND_BC, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h8000, 0);
      // negative radius
      send_pair(sot_pkg::KIND_BC, 0, 0, 32'h40000, 32'h40000, 32'h20000, 32'h20000,
                32'hFFFF0000, 0);
      send_pair(sot_pkg::KIND_BC, 0, 0, 32'h10000, 32'h10000, 32'h8000, 32'h8000, neg, 0);
      send_pair(sot_pkg::KIND_BC, neg, neg, big, big, 0, 0, big, big);
      // circle-circle
      send_pair(sot_pkg::KIND_CC, 0, 0, 32'h10000, 0, 32'h18000, 0, 32'h10000, 0);
      send_pair(sot_pkg::KIND_CC, 0, 0, 32'h10000, 0, 32'h20000, 0, 32'h10000, 0);
      send_pair(sot_pkg::KIND_CC, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(sot_pkg::KIND_CC, 0, 0, 32'hFFFF0000, 0, 0, 0, 32'h8000, 0);
      send_pair(sot_pkg::KIND_CC, neg, neg, big, big, big, big, big, neg);
      send_pair(3'd4, 0, 0, 32'h10000, 32'h10000, 0, 0, 32'h10000, 32'h10000);
      send_pair(3'd7, big, neg, big, neg, neg, big, neg, big);

      // random pairs, with a pause until drained midway
      for (int n = 0; n < 1500; n++) begin
         if (n == 750) begin
            req_valid <= 0;
            @(posedge clock);
            wait (pending == 0);
         end
         send_random_pair();
      end
      req_valid <= 0;
      @(posedge clock);

      wait (pending == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

[filelist.f]
hdl/sot_pkg.sv
hdl/sot_front.sv
hdl/sot_fifo.sv
hdl/sot_isqrt.sv
hdl/sot_back.sv
hdl/shape_overlap_test_2d.sv
hdl/sot_checker.sv
test/shape_overlap_checker.sv
test/shape_overlap_test_2d_tb.sv
